>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, each disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tnh_pkg.sv
// ----------------------------------------------------------------------------
// tnh_pkg
// Constants and types shared by the tag name histogram unit.
// ----------------------------------------------------------------------------
package tnh_pkg;

   // Default sizing
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int MAX_NAME_DEF    = 16;
   localparam int COUNT_BITS_DEF  = 16;

   // Fixed field widths of the channels
   localparam int CH_W        = 8;
   localparam int SLOT_W      = 5;
   localparam int COUNT_OUT_W = 16;

   // Character codes
   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
   localparam logic [CH_W-1:0] CH_GT    = 8'h3E;

   // Lookup request from the parser to the table
   typedef struct packed {
      logic start;
      logic cut;
   } launch_type;

endpackage

>>> hdl/tnh_if.sv
// ----------------------------------------------------------------------------
// tnh_if
// Valid/ready channels for characters in and histogram results out.
// ----------------------------------------------------------------------------
interface tnh_req_if;
   logic                     valid;
   logic                     ready;
   logic [tnh_pkg::CH_W-1:0] ch;
   logic                     last_char;

   modport source (output valid, output ch, output last_char, input ready);
   modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface tnh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tnh_pkg::SLOT_W-1:0]      slot;
   logic [tnh_pkg::COUNT_OUT_W-1:0] tag_count;
   logic                            is_new;
   logic                            table_full;
   logic                            name_cut;

   modport source (output valid, output slot, output tag_count, output is_new,
                   output table_full, output name_cut, input ready);
   modport sink   (input valid, input slot, input tag_count, input is_new,
                   input table_full, input name_cut, output ready);
endinterface

>>> hdl/tnh_parser.sv
// ----------------------------------------------------------------------------
// tnh_parser
// Character parser: tracks tag openings and collects the current tag name.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnh_parser #(
   parameter int MAX_NAME = tnh_pkg::MAX_NAME_DEF,
   localparam int LEN_W   = $clog2(MAX_NAME + 1),
   localparam int NAME_W  = MAX_NAME * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [tnh_pkg::CH_W-1:0] ch,
   input  logic                     last_char,
   output tnh_pkg::launch_type      launch,
   output logic [NAME_W-1:0]        name_out,
   output logic [LEN_W-1:0]         len_out
);

   localparam logic [1:0] MODE_OUTSIDE = 2'd0;
   localparam logic [1:0] MODE_OPENED  = 2'd1;
   localparam logic [1:0] MODE_NAME    = 2'd2;

   logic [1:0]        mode_ff, mode_in;
   logic              ended_ff, ended_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              is_term;
   logic              start;

   assign is_term = (ch == tnh_pkg::CH_GT) || (ch == tnh_pkg::CH_SPACE) ||
                    (ch == tnh_pkg::CH_NL) || (ch == tnh_pkg::CH_LT);

   always_comb begin
      mode_in  = mode_ff;
      ended_in = ended_ff;
      name_in  = name_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      start    = 1'b0;
      if (accept) begin
         if (!ended_ff) begin
            if (ch == tnh_pkg::CH_NUL) begin
               // drop any unfinished name and ignore the rest of the buffer
               ended_in = 1'b1;
               mode_in  = MODE_OUTSIDE;
               len_in   = '0;
               ovf_in   = 1'b0;
            end else if (mode_ff == MODE_OUTSIDE) begin
               if (ch == tnh_pkg::CH_LT) begin
                  mode_in = MODE_OPENED;
                  len_in  = '0;
                  ovf_in  = 1'b0;
               end
            end else if ((mode_ff == MODE_OPENED) && (ch == tnh_pkg::CH_SLASH)) begin
               mode_in = MODE_OUTSIDE;
            end else if (is_term) begin
               start   = (len_ff != '0);
               len_in  = '0;
               ovf_in  = 1'b0;
               mode_in = (ch == tnh_pkg::CH_LT) ? MODE_OPENED : MODE_OUTSIDE;
            end else begin
               mode_in = MODE_NAME;
               if (len_ff < LEN_W'(MAX_NAME)) begin
                  for (int j = 0; j < MAX_NAME; j++) begin
                     if (LEN_W'(j) == len_ff) begin
                        name_in[j*8 +: 8] = ch;
                     end
                  end
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         if (last_char) begin
            mode_in  = MODE_OUTSIDE;
            ended_in = 1'b0;
            len_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OUTSIDE;
         ended_ff <= 1'b0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         ended_ff <= ended_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff <= name_in;
   end

   assign launch.start = start;
   assign launch.cut   = ovf_ff;
   assign name_out     = name_ff;
   assign len_out      = len_ff;

   `ASSERT_ALWAYS(a_len_bound, clock, reset, len_ff <= LEN_W'(MAX_NAME), "name length beyond max")
   `ASSERT_IMPLY(a_ovf_full, clock, reset, ovf_ff, len_ff == LEN_W'(MAX_NAME), "overflow with short name")

endmodule

>>> hdl/tnh_table.sv
// ----------------------------------------------------------------------------
// tnh_table
// Name table in a synchronous memory: walks the entries one per cycle,
// bumps the count on a hit, appends on a miss when the table has room, and holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnh_table #(
   parameter int TABLE_DEPTH = tnh_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_NAME    = tnh_pkg::MAX_NAME_DEF,
   parameter int COUNT_BITS  = tnh_pkg::COUNT_BITS_DEF,
   localparam int LEN_W      = $clog2(MAX_NAME + 1),
   localparam int NAME_W     = MAX_NAME * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tnh_pkg::launch_type             launch,
   input  logic [NAME_W-1:0]               key_name,
   input  logic [LEN_W-1:0]                key_len,
   output logic                            idle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tnh_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [tnh_pkg::COUNT_OUT_W-1:0] rsp_tag_count,
   output logic                            rsp_is_new,
   output logic                            rsp_table_full,
   output logic                            rsp_name_cut
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int ENT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   typedef struct packed {
      logic [NAME_W-1:0]     name;
      logic [LEN_W-1:0]      len;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   entry_type mem [TABLE_DEPTH];

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ENT_W-1:0]      entries_ff, entries_in;
   logic [NAME_W-1:0]     key_name_ff;
   logic [LEN_W-1:0]      key_len_ff;
   logic                  key_cut_ff;
   entry_type             rdata_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_slot_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_new_ff;
   logic                  rsp_full_ff;
   logic                  rsp_cut_ff;

   logic                  load;
   logic                  do_append;
   logic [IDX_W-1:0]      res_slot;
   logic [COUNT_BITS-1:0] res_count;
   logic                  res_new;
   logic                  res_full;

   logic                  hit;
   logic                  bytes_same;
   logic                  last_entry;
   logic                  table_full;
   logic                  out_free;
   logic [COUNT_BITS-1:0] bumped;
   logic [31:0]           slot_wide;
   logic [31:0]           count_wide;

   // Compare only the kept bytes of the key against the entry just read
   always_comb begin
      bytes_same = 1'b1;
      for (int j = 0; j < MAX_NAME; j++) begin
         if ((LEN_W'(j) < key_len_ff) &&
             (rdata_ff.name[j*8 +: 8] != key_name_ff[j*8 +: 8])) begin
            bytes_same = 1'b0;
         end
      end
   end

   assign hit        = (rdata_ff.len == key_len_ff) && bytes_same;
   assign last_entry = ((ENT_W'(idx_ff) + ENT_W'(1)) == entries_ff);
   assign table_full = (entries_ff == ENT_W'(TABLE_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign bumped     = (rdata_ff.count == '1) ? rdata_ff.count
                                              : rdata_ff.count + COUNT_BITS'(1);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      entries_in = entries_ff;
      rd_addr    = idx_ff + IDX_W'(1);
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rdata_ff;
      load       = 1'b0;
      do_append  = 1'b0;
      res_slot   = idx_ff;
      res_count  = '0;
      res_new    = 1'b0;
      res_full   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch.start) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            rd_addr = '0;
            // wait until the output register can take the result
            if (out_free) begin
               if (entries_ff == '0) begin
                  do_append = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (hit) begin
               wr_en         = 1'b1;
               wr_data.count = bumped;
               load          = 1'b1;
               res_count     = bumped;
               state_in      = ST_IDLE;
            end else if (last_entry) begin
               do_append = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (do_append) begin
         load = 1'b1;
         if (table_full) begin
            res_full = 1'b1;
            res_slot = '0;
         end else begin
            wr_en      = 1'b1;
            wr_addr    = entries_ff[IDX_W-1:0];
            wr_data    = '{name: key_name_ff, len: key_len_ff, count: COUNT_BITS'(1)};
            res_slot   = entries_ff[IDX_W-1:0];
            res_count  = COUNT_BITS'(1);
            res_new    = 1'b1;
            entries_in = entries_ff + ENT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         entries_ff <= entries_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if ((state_ff == ST_IDLE) && launch.start) begin
         key_name_ff <= key_name;
         key_len_ff  <= key_len;
         key_cut_ff  <= launch.cut;
      end
      if (load) begin
         rsp_slot_ff  <= res_slot;
         rsp_count_ff <= res_count;
         rsp_new_ff   <= res_new;
         rsp_full_ff  <= res_full;
         rsp_cut_ff   <= key_cut_ff;
      end
   end

   assign slot_wide      = 32'(rsp_slot_ff);
   assign count_wide     = 32'(rsp_count_ff);
   assign idle           = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = slot_wide[tnh_pkg::SLOT_W-1:0];
   assign rsp_tag_count  = count_wide[tnh_pkg::COUNT_OUT_W-1:0];
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_name_cut   = rsp_cut_ff;

   `ASSERT_ALWAYS(a_entries_bound, clock, reset, entries_ff <= ENT_W'(TABLE_DEPTH), "table overfilled")
   `ASSERT_IMPLY(a_load_free, clock, reset, load, !rsp_valid_ff || rsp_ready, "result overwrites pending result")
   `ASSERT_IMPLY(a_new_full_excl, clock, reset, rsp_valid_ff, !(rsp_new_ff && rsp_full_ff), "new and full both set")
   `ASSERT_NEXT(a_append_grows, clock, reset, load && res_new, entries_ff == $past(entries_ff) + ENT_W'(1), "append did not grow table")

endmodule

>>> hdl/tag_name_histogram_unit.sv
// ----------------------------------------------------------------------------
// tag_name_histogram_unit
// Counts distinct tag names in a stream of markup characters.
// ----------------------------------------------------------------------------
// Usage: characters enter on req_chan (ch, last_char), one transaction per
// character. A finished, non-empty opening tag name yields one transaction on
// rsp_chan with its table slot, updated count, and new / full / cut flags.
// A character that finishes a tag starts a table lookup: a start state
// issues the read of the first entry (held there while an earlier result
// still waits on rsp_chan), then the walk compares the stored names in
// order, one entry per cycle, until a hit or the last name stored; an empty
// table skips the walk. The result lands in the output register, and
// req_chan.ready is low for that whole lookup.
// Reset clears the parse state and empties the table; no clearing pass is
// needed, since only entries below the fill count are ever compared.
// A stalled receiver holds the result in the output register; characters
// keep flowing until the next tag finishes.
// ----------------------------------------------------------------------------
module tag_name_histogram_unit #(
   parameter int TABLE_DEPTH = tnh_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_NAME    = tnh_pkg::MAX_NAME_DEF,
   parameter int COUNT_BITS  = tnh_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   tnh_req_if.sink     req_chan,
   tnh_rsp_if.source   rsp_chan
);

   localparam int LEN_W  = $clog2(MAX_NAME + 1);
   localparam int NAME_W = MAX_NAME * 8;

   tnh_pkg::launch_type launch;
   logic [NAME_W-1:0]   name;
   logic [LEN_W-1:0]    len;
   logic                table_idle;
   logic                accept;

   assign req_chan.ready = table_idle;
   assign accept         = req_chan.valid && table_idle;

   tnh_parser #(
      .MAX_NAME (MAX_NAME)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_chan.ch),
      .last_char (req_chan.last_char),
      .launch    (launch),
      .name_out  (name),
      .len_out   (len)
   );

   tnh_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_NAME    (MAX_NAME),
      .COUNT_BITS  (COUNT_BITS)
   ) u_table (
      .clock          (clock),
      .reset          (reset),
      .launch         (launch),
      .key_name       (name),
      .key_len        (len),
      .idle           (table_idle),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_slot       (rsp_chan.slot),
      .rsp_tag_count  (rsp_chan.tag_count),
      .rsp_is_new     (rsp_chan.is_new),
      .rsp_table_full (rsp_chan.table_full),
      .rsp_name_cut   (rsp_chan.name_cut)
   );

endmodule

>>> test/tag_name_histogram_unit_test.sv
// ----------------------------------------------------------------------------
// tag_name_histogram_unit_test
// Self-checking bench for the tag name histogram unit. Characters go in on
// the request channel. A model of the parser and name table, kept in a small
// class, predicts each histogram transaction, and every response is checked
// against it field by field. The bench runs directed markup first. Random
// markup from a pool of names follows, through phases of sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module tag_name_histogram_unit_test;

   localparam int SLOTS        = tnh_pkg::TABLE_DEPTH_DEF;
   localparam int NAME_MAX     = tnh_pkg::MAX_NAME_DEF;
   localparam int SLOT_BITS    = tnh_pkg::SLOT_W;
   localparam int CNT_BITS     = tnh_pkg::COUNT_OUT_W;
   localparam int COUNT_MAX    = (1 << tnh_pkg::COUNT_BITS_DEF) - 1;
   localparam int POOL_SIZE    = 48;
   localparam int POOL_CHARS   = 24;
   localparam int RANDOM_CHARS = 560;
   localparam int PHASES       = 4;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int DRAIN_LIMIT  = 20_000;
   localparam int SETTLE       = 2 * (SLOTS + 2);

   typedef enum logic [1:0] {PS_OUTSIDE, PS_OPENED, PS_IN_NAME} parse_state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic [CNT_BITS-1:0]  tag_count;
      logic                 is_new;
      logic                 table_full;
      logic                 name_cut;
   } tag_result_type;

   class tag_tally;
      parse_state_type mode;
      bit              ended;
      logic [7:0]      cur_name [NAME_MAX];
      int              cur_len;
      bit              cur_cut;
      logic [7:0]      names [SLOTS][NAME_MAX];
      int              lens [SLOTS];
      int              counts [SLOTS];
      int              used;
      tag_result_type  expected_tags [$];
      int              errors;

      function new();
         mode    = PS_OUTSIDE;
         ended   = 0;
         cur_len = 0;
         cur_cut = 0;
         used    = 0;
         errors  = 0;
      endfunction

      static function bit is_delim(logic [7:0] c);
         return c == tnh_pkg::CH_GT || c == tnh_pkg::CH_SPACE ||
                c == tnh_pkg::CH_NL || c == tnh_pkg::CH_LT;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void clear_name();
         cur_len = 0;
         cur_cut = 0;
      endfunction

      // Look the finished name up, then update the table as the block does
      function void finish_name();
         int             hit_at;
         bit             same;
         tag_result_type r;
         if (cur_len == 0) return;
         hit_at = -1;
         for (int e = 0; e < used; e++) begin
            if (hit_at < 0 && lens[e] == cur_len) begin
               same = 1;
               for (int k = 0; k < cur_len; k++)
                  if (names[e][k] !== cur_name[k]) same = 0;
               if (same) hit_at = e;
            end
         end
         r = '0;
         r.name_cut = cur_cut;
         if (hit_at >= 0) begin
            if (counts[hit_at] < COUNT_MAX) counts[hit_at]++;
            r.slot      = hit_at[SLOT_BITS-1:0];
            r.tag_count = counts[hit_at][CNT_BITS-1:0];
         end else if (used < SLOTS) begin
            for (int k = 0; k < cur_len; k++) names[used][k] = cur_name[k];
            lens[used]   = cur_len;
            counts[used] = 1;
            r.slot       = used[SLOT_BITS-1:0];
            r.tag_count  = CNT_BITS'(1);
            r.is_new     = 1'b1;
            used++;
         end else begin
            r.table_full = 1'b1;
         end
         expected_tags.push_back(r);
      endfunction

      function void note_char(logic [7:0] c, logic lst);
         if (!ended) begin
            if (c == tnh_pkg::CH_NUL) begin
               ended = 1;
               mode  = PS_OUTSIDE;
               clear_name();
            end else if (mode == PS_OUTSIDE) begin
               if (c == tnh_pkg::CH_LT) begin
                  mode = PS_OPENED;
                  clear_name();
               end
            end else if (mode == PS_OPENED && c == tnh_pkg::CH_SLASH) begin
               mode = PS_OUTSIDE;
            end else if (is_delim(c)) begin
               finish_name();
               clear_name();
               mode = (c == tnh_pkg::CH_LT) ? PS_OPENED : PS_OUTSIDE;
            end else begin
               mode = PS_IN_NAME;
               if (cur_len < NAME_MAX) begin
                  cur_name[cur_len] = c;
                  cur_len++;
               end else begin
                  cur_cut = 1;
               end
            end
         end
         // The table survives the end of a buffer; the parse state does not
         if (lst) begin
            mode  = PS_OUTSIDE;
            ended = 0;
            clear_name();
         end
      endfunction

      task check_result(tag_result_type got);
         tag_result_type want;
         if (expected_tags.size() == 0) begin
            report($sformatf("unexpected result slot %0d count %0d",
                             got.slot, got.tag_count));
            return;
         end
         want = expected_tags.pop_front();
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", got.slot, want.slot));
         if (got.tag_count !== want.tag_count)
            report($sformatf("tag_count %0d, want %0d", got.tag_count, want.tag_count));
         if (got.is_new !== want.is_new)
            report($sformatf("is_new %0b, want %0b", got.is_new, want.is_new));
         if (got.table_full !== want.table_full)
            report($sformatf("table_full %0b, want %0b", got.table_full, want.table_full));
         if (got.name_cut !== want.name_cut)
            report($sformatf("name_cut %0b, want %0b", got.name_cut, want.name_cut));
      endtask
   endclass

   logic clock;
   logic reset;

   tnh_req_if req_chan ();
   tnh_rsp_if rsp_chan ();

   tag_name_histogram_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tag_tally   tally;
   int         idle_pct;
   int         stall_pct;
   int         sent;
   int         cycles;
   logic [7:0] pool_ch [POOL_SIZE][POOL_CHARS];
   int         pool_len [POOL_SIZE];

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Check accepted results, then pick the next ready value
   initial begin
      tag_result_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.slot       = rsp_chan.slot;
            got.tag_count  = rsp_chan.tag_count;
            got.is_new     = rsp_chan.is_new;
            got.table_full = rsp_chan.table_full;
            got.name_cut   = rsp_chan.name_cut;
            tally.check_result(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [7:0] name_char(bit first);
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (tag_tally::is_delim(c) || (first && c == tnh_pkg::CH_SLASH))
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   function void build_pool();
      int sel;
      for (int n = 0; n < POOL_SIZE; n++) begin
         sel = $urandom_range(99);
         if (sel < 70)      pool_len[n] = $urandom_range(1, 5);
         else if (sel < 90) pool_len[n] = $urandom_range(6, NAME_MAX);
         else               pool_len[n] = $urandom_range(NAME_MAX + 1, POOL_CHARS);
         for (int k = 0; k < POOL_CHARS; k++) pool_ch[n][k] = name_char(k == 0);
      end
      // Two overlong names that differ only past the kept prefix
      pool_len[POOL_SIZE-2] = POOL_CHARS;
      pool_len[POOL_SIZE-1] = NAME_MAX + 3;
      for (int k = 0; k < NAME_MAX; k++) pool_ch[POOL_SIZE-1][k] = pool_ch[POOL_SIZE-2][k];
   endfunction

   task send_char(logic [7:0] c, logic lst);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.ch        <= c;
      req_chan.last_char <= lst;
      do @(posedge clock); while (!req_chan.ready);
      tally.note_char(c, lst);
      sent++;
   endtask

   task send_text(string s, bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], last_at_end && i == s.len() - 1);
   endtask

   task send_pool_name(int n);
      for (int k = 0; k < pool_len[n]; k++) send_char(pool_ch[n][k], 1'b0);
   endtask

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(3))
         0:       return tnh_pkg::CH_GT;
         1:       return tnh_pkg::CH_SPACE;
         2:       return tnh_pkg::CH_NL;
         default: return tnh_pkg::CH_LT;
      endcase
   endfunction

   // One stretch of random markup: mostly well-formed tags, some noise
   task random_unit();
      int         sel;
      int         n;
      logic [7:0] d;
      sel = $urandom_range(99);
      n   = $urandom_range(POOL_SIZE - 1);
      if (sel < 65) begin
         send_char(tnh_pkg::CH_LT, 1'b0);
         send_pool_name(n);
         d = pick_delim();
         send_char(d, $urandom_range(19) == 0);
         if (d == tnh_pkg::CH_SPACE && $urandom_range(1)) send_text("k=v>", 1'b0);
      end else if (sel < 75) begin
         send_char(tnh_pkg::CH_LT, 1'b0);
         send_char(tnh_pkg::CH_SLASH, 1'b0);
         send_pool_name(n);
         send_char(tnh_pkg::CH_GT, 1'b0);
      end else if (sel < 87) begin
         repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(1, 255)), $urandom_range(24) == 0);
      end else if (sel < 93) begin
         // Drop a partial name at a zero, then flush the buffer
         send_char(tnh_pkg::CH_LT, 1'b0);
         for (int k = 0; k < $urandom_range(pool_len[n]); k++)
            send_char(pool_ch[n][k], 1'b0);
         send_char(tnh_pkg::CH_NUL, 1'b0);
         repeat ($urandom_range(4)) send_char(8'($urandom_range(255)), 1'b0);
         send_char(8'($urandom_range(255)), 1'b1);
      end else begin
         send_char(8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      int target;
      int guard;
      tally              = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.ch        = '0;
      req_chan.last_char = 1'b0;
      idle_pct           = 0;
      stall_pct          = 0;
      sent               = 0;
      build_pool();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("<a>", 1'b0);
      send_text("<a><a", 1'b0);
      send_char(tnh_pkg::CH_GT, 1'b0);

      send_text("</b>", 1'b0);
      send_text("<>", 1'b0);
      send_text("<<c>", 1'b0);
      send_text("< x>", 1'b0);
      send_text("<abcdefghijklmnopqrstu ", 1'b0);
      send_text("<abcdefghijklmnopZZ\n", 1'b0);
      send_text("<ab><abc><x/y>", 1'b0);
      send_text("<dd", 1'b0);
      send_char(tnh_pkg::CH_NUL, 1'b0);
      send_text("<e>q", 1'b1);
      send_text("<e>", 1'b0);
      send_text("<f>", 1'b1);
      send_text("<g", 1'b1);
      send_text("h>", 1'b0);
      send_char(tnh_pkg::CH_LT, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'h7F, 1'b0);
      send_char(tnh_pkg::CH_GT, 1'b0);
      send_char(tnh_pkg::CH_NUL, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 56; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 23; stall_pct = 23; end
         endcase
         target = sent + RANDOM_CHARS / PHASES;
         while (sent < target) random_unit();
      end
      req_chan.valid <= 1'b0;

      guard = 0;
      while (tally.expected_tags.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
      if (tally.expected_tags.size() != 0)
         tally.report($sformatf("%0d results never arrived", tally.expected_tags.size()));

      if (tally.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hdl
hdl/tnh_pkg.sv
hdl/tnh_if.sv
hdl/tnh_parser.sv
hdl/tnh_table.sv
hdl/tag_name_histogram_unit.sv
test/tag_name_histogram_unit_test.sv
